>>> hdl/rfk_pkg.sv
package rfk_pkg;

  // Port widths fixed by the word formats.
  localparam int OFFSET_W = 16;
  localparam int WEIGHT_W = 16;
  localparam int MODE_W   = 3;

  // Default fixed-point formats.
  localparam int IN_FRAC_DEF  = 12;
  localparam int OUT_FRAC_DEF = 14;

  // Filter mode register codes.
  localparam logic [MODE_W-1:0] MODE_BOX      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TRIANGLE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HERMITE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BELL     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BSPLINE  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MITCHELL = 3'd5;

  // One polynomial piece of one filter; the inner and outer pieces are separate.
  typedef enum logic [3:0] {
    PC_ZERO,
    PC_BOX,
    PC_TRI,
    PC_HERM,
    PC_BELL_IN,
    PC_BELL_OUT,
    PC_BSP_IN,
    PC_BSP_OUT,
    PC_MIT_IN,
    PC_MIT_OUT
  } piece_t;

  // Odd factor of the piece denominator.
  typedef enum logic [1:0] {
    DIV_1,
    DIV_3,
    DIV_9
  } odd_div_t;

  // num = c3*v^3 + c2*v^2*s + c1*v*s^2 + c0*s^3, divided by odd * 2^pow2.
  typedef struct packed {
    logic signed [7:0] c3;
    logic signed [7:0] c2;
    logic signed [7:0] c1;
    logic signed [7:0] c0;
    odd_div_t          odd;
    logic [1:0]        pow2;
  } coef_t;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic   valid;
    piece_t piece;
  } ctl_t;

  // Coefficients and denominator of each piece.
  function automatic coef_t piece_coef(piece_t p);
    coef_t c;
    c      = '0;
    c.odd  = DIV_1;
    case (p)
      PC_BOX: begin
        c.c0 = 8'sd1;
      end
      PC_TRI: begin
        c.c1 = -8'sd1;
        c.c0 = 8'sd1;
      end
      PC_HERM: begin
        c.c3 = 8'sd2;
        c.c2 = -8'sd3;
        c.c0 = 8'sd1;
      end
      PC_BELL_IN: begin
        c.c2   = -8'sd4;
        c.c0   = 8'sd3;
        c.pow2 = 2'd2;
      end
      PC_BELL_OUT: begin
        c.c2   = 8'sd1;
        c.pow2 = 2'd3;
      end
      PC_BSP_IN: begin
        c.c3   = 8'sd3;
        c.c2   = -8'sd6;
        c.c0   = 8'sd4;
        c.odd  = DIV_3;
        c.pow2 = 2'd1;
      end
      PC_BSP_OUT: begin
        c.c3   = 8'sd1;
        c.odd  = DIV_3;
        c.pow2 = 2'd1;
      end
      PC_MIT_IN: begin
        c.c3   = 8'sd21;
        c.c2   = -8'sd36;
        c.c0   = 8'sd16;
        c.odd  = DIV_9;
        c.pow2 = 2'd1;
      end
      PC_MIT_OUT: begin
        c.c3   = -8'sd7;
        c.c2   = 8'sd36;
        c.c1   = -8'sd60;
        c.c0   = 8'sd32;
        c.odd  = DIV_9;
        c.pow2 = 2'd1;
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

endpackage

>>> hdl/resampling_filter_kernel_eval_top.sv
// Throughput: one word per cycle, through a ten-stage pipeline (two cascaded multipliers
// for the powers, term scaling, a two-level sum, rounding and a reciprocal divide).
// A stall at the output holds every stage; in_ready follows out_ready combinationally.
// Reset (rst_n low, synchronous) clears all valid bits and sets filter_mode to box.
module resampling_filter_kernel_eval_top #(
  parameter int IN_FRAC_BITS  = rfk_pkg::IN_FRAC_DEF,
  parameter int OUT_FRAC_BITS = rfk_pkg::OUT_FRAC_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rfk_pkg::MODE_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rfk_pkg::OFFSET_W-1:0]  in_offset,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rfk_pkg::WEIGHT_W-1:0]  out_weight
);

  logic [rfk_pkg::MODE_W-1:0]          filter_mode_r;
  logic [rfk_pkg::MODE_W-1:0]          filter_mode_nxt;
  logic                                adv;
  rfk_pkg::ctl_t                       front_ctl;
  logic [IN_FRAC_BITS+1:0]             front_v;
  rfk_pkg::ctl_t                       poly_ctl;
  logic signed [3*IN_FRAC_BITS+10:0]   poly_num;

  // Mode register; a write is taken in any cycle.
  assign cfg_ready       = 1'b1;
  assign filter_mode_nxt = (cfg_valid && cfg_ready) ? cfg_data : filter_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r <= rfk_pkg::MODE_BOX;
    end else begin
      filter_mode_r <= filter_mode_nxt;
    end
  end

  // The whole pipeline moves unless a finished word waits at the output.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  rfk_front #(
    .IN_FRAC_BITS (IN_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_offset (in_offset),
    .mode      (filter_mode_r),
    .ctl_o     (front_ctl),
    .v_o       (front_v)
  );

  rfk_poly #(
    .IN_FRAC_BITS (IN_FRAC_BITS)
  ) u_poly (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl_i (front_ctl),
    .v_i   (front_v),
    .ctl_o (poly_ctl),
    .num_o (poly_num)
  );

  rfk_round #(
    .IN_FRAC_BITS  (IN_FRAC_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_round (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .ctl_i      (poly_ctl),
    .num_i      (poly_num),
    .out_valid  (out_valid),
    .out_weight (out_weight)
  );

endmodule

>>> hdl/rfk_front.sv
module rfk_front #(
  parameter int IN_FRAC_BITS = rfk_pkg::IN_FRAC_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     adv,
  input  logic                                     in_valid,
  input  logic signed [rfk_pkg::OFFSET_W-1:0]      in_offset,
  input  logic [rfk_pkg::MODE_W-1:0]               mode,
  output rfk_pkg::ctl_t                            ctl_o,
  output logic [IN_FRAC_BITS+1:0]                  v_o
);

  localparam int F  = IN_FRAC_BITS;
  localparam int VW = F + 2;
  localparam int CW = (F + 3 > 18) ? F + 3 : 18;

  localparam logic signed [CW-1:0] ONE_S   = CW'(longint'(1) <<< F);
  localparam logic signed [CW-1:0] TWO_S   = CW'(longint'(2) <<< F);
  localparam logic signed [CW-1:0] THREE_S = CW'(longint'(3) <<< F);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] x2;
  logic signed [CW-1:0] ax;
  logic signed [CW-1:0] a2;
  logic signed [CW-1:0] vs;
  rfk_pkg::piece_t      piece_nxt;
  rfk_pkg::ctl_t        ctl_nxt;
  rfk_pkg::ctl_t        ctl_r;
  logic [VW-1:0]        v_nxt;
  logic [VW-1:0]        v_r;

  // Offset, twice the offset and their magnitudes.
  assign xs = CW'(in_offset);
  assign x2 = xs <<< 1;
  assign ax = (xs < 0) ? -xs : xs;
  assign a2 = ax <<< 1;

  // Pick the polynomial piece and its variable for the selected filter.
  always_comb begin
    piece_nxt = rfk_pkg::PC_ZERO;
    vs        = '0;
    case (mode)
      rfk_pkg::MODE_BOX: begin
        if (x2 > -ONE_S && x2 <= ONE_S) begin
          piece_nxt = rfk_pkg::PC_BOX;
        end
      end
      rfk_pkg::MODE_TRIANGLE: begin
        if (ax < ONE_S) begin
          piece_nxt = rfk_pkg::PC_TRI;
          vs        = ax;
        end
      end
      rfk_pkg::MODE_HERMITE: begin
        if (ax < ONE_S) begin
          piece_nxt = rfk_pkg::PC_HERM;
          vs        = ax;
        end
      end
      rfk_pkg::MODE_BELL: begin
        if (a2 < ONE_S) begin
          piece_nxt = rfk_pkg::PC_BELL_IN;
          vs        = ax;
        end else if (a2 < THREE_S) begin
          piece_nxt = rfk_pkg::PC_BELL_OUT;
          vs        = THREE_S - a2;
        end
      end
      rfk_pkg::MODE_BSPLINE: begin
        if (ax < ONE_S) begin
          piece_nxt = rfk_pkg::PC_BSP_IN;
          vs        = ax;
        end else if (ax < TWO_S) begin
          piece_nxt = rfk_pkg::PC_BSP_OUT;
          vs        = TWO_S - ax;
        end
      end
      rfk_pkg::MODE_MITCHELL: begin
        if (ax < ONE_S) begin
          piece_nxt = rfk_pkg::PC_MIT_IN;
          vs        = ax;
        end else if (ax < TWO_S) begin
          piece_nxt = rfk_pkg::PC_MIT_OUT;
          vs        = ax;
        end
      end
      default: begin
        piece_nxt = rfk_pkg::PC_ZERO;
      end
    endcase
  end

  assign ctl_nxt.valid = in_valid;
  assign ctl_nxt.piece = piece_nxt;
  assign v_nxt         = vs[VW-1:0];

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r <= v_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign v_o   = v_r;

endmodule

>>> hdl/rfk_poly.sv
module rfk_poly #(
  parameter int IN_FRAC_BITS = rfk_pkg::IN_FRAC_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  rfk_pkg::ctl_t                        ctl_i,
  input  logic [IN_FRAC_BITS+1:0]              v_i,
  output rfk_pkg::ctl_t                        ctl_o,
  output logic signed [3*IN_FRAC_BITS+10:0]    num_o
);

  localparam int F  = IN_FRAC_BITS;
  localparam int VW = F + 2;
  localparam int NW = 3 * F + 11;

  rfk_pkg::ctl_t         ctl_b_r;
  rfk_pkg::ctl_t         ctl_c_r;
  rfk_pkg::ctl_t         ctl_d_r;
  rfk_pkg::ctl_t         ctl_e_r;
  rfk_pkg::ctl_t         ctl_f_r;
  rfk_pkg::coef_t        cf;

  logic [VW-1:0]         v_b_r;
  logic [2*VW-1:0]       sq_nxt;
  logic [2*VW-1:0]       sq_b_r;
  logic [VW-1:0]         v_c_r;
  logic [2*VW-1:0]       sq_c_r;
  logic [3*VW-1:0]       cube_nxt;
  logic [3*VW-1:0]       cube_c_r;

  logic signed [NW-1:0]  vx;
  logic signed [NW-1:0]  sqx;
  logic signed [NW-1:0]  cubex;
  logic signed [NW-1:0]  t3_nxt;
  logic signed [NW-1:0]  t2_nxt;
  logic signed [NW-1:0]  t1_nxt;
  logic signed [NW-1:0]  t0_nxt;
  logic signed [NW-1:0]  t3_d_r;
  logic signed [NW-1:0]  t2_d_r;
  logic signed [NW-1:0]  t1_d_r;
  logic signed [NW-1:0]  t0_d_r;
  logic signed [NW-1:0]  hi_nxt;
  logic signed [NW-1:0]  lo_nxt;
  logic signed [NW-1:0]  hi_e_r;
  logic signed [NW-1:0]  lo_e_r;
  logic signed [NW-1:0]  num_nxt;
  logic signed [NW-1:0]  num_f_r;

  // Square, then cube, each behind its own register.
  assign sq_nxt   = v_i * v_i;
  assign cube_nxt = sq_b_r * v_b_r;

  // Scale each power by the coefficient of its piece.
  assign cf     = rfk_pkg::piece_coef(ctl_c_r.piece);
  assign vx     = signed'(NW'(v_c_r));
  assign sqx    = signed'(NW'(sq_c_r));
  assign cubex  = signed'(NW'(cube_c_r));
  assign t3_nxt = cubex * cf.c3;
  assign t2_nxt = sqx * cf.c2;
  assign t1_nxt = vx * cf.c1;
  assign t0_nxt = NW'(cf.c0);

  // Align the terms to s^3 and add them in two levels.
  assign hi_nxt  = t3_d_r + (t2_d_r <<< F);
  assign lo_nxt  = (t1_d_r <<< (2 * F)) + (t0_d_r <<< (3 * F));
  assign num_nxt = hi_e_r + lo_e_r;

  // Valid bits and piece codes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
      ctl_c_r <= '0;
      ctl_d_r <= '0;
      ctl_e_r <= '0;
      ctl_f_r <= '0;
    end else if (adv) begin
      ctl_b_r <= ctl_i;
      ctl_c_r <= ctl_b_r;
      ctl_d_r <= ctl_c_r;
      ctl_e_r <= ctl_d_r;
      ctl_f_r <= ctl_e_r;
    end
  end

  // Data stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      v_b_r    <= v_i;
      sq_b_r   <= sq_nxt;
      v_c_r    <= v_b_r;
      sq_c_r   <= sq_b_r;
      cube_c_r <= cube_nxt;
      t3_d_r   <= t3_nxt;
      t2_d_r   <= t2_nxt;
      t1_d_r   <= t1_nxt;
      t0_d_r   <= t0_nxt;
      hi_e_r   <= hi_nxt;
      lo_e_r   <= lo_nxt;
      num_f_r  <= num_nxt;
    end
  end

  assign ctl_o = ctl_f_r;
  assign num_o = num_f_r;

endmodule

>>> hdl/rfk_round.sv
module rfk_round #(
  parameter int IN_FRAC_BITS  = rfk_pkg::IN_FRAC_DEF,
  parameter int OUT_FRAC_BITS = rfk_pkg::OUT_FRAC_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  rfk_pkg::ctl_t                        ctl_i,
  input  logic signed [3*IN_FRAC_BITS+10:0]    num_i,
  output logic                                 out_valid,
  output logic signed [rfk_pkg::WEIGHT_W-1:0]  out_weight
);

  localparam int F  = IN_FRAC_BITS;
  localparam int O  = OUT_FRAC_BITS;
  localparam int NW = 3 * F + 11;
  localparam int K  = 3 * F - O;
  localparam int QW = O + 5;
  localparam int QB = O + 2;
  localparam int S  = QW + 4;
  localparam int PW = QW + S;
  localparam int EW = (O + 3 > 17) ? O + 3 : 17;
  localparam int WW = rfk_pkg::WEIGHT_W;

  // Reciprocals rounded up; exact for every quotient below 2^QW.
  localparam logic [S-1:0] RECIP3 = S'(((64'd1 << S) + 64'd2) / 64'd3);
  localparam logic [S-1:0] RECIP9 = S'(((64'd1 << S) + 64'd8) / 64'd9);

  localparam logic signed [EW-1:0] W_MAX = EW'((longint'(1) <<< (WW - 1)) - 1);
  localparam logic signed [EW-1:0] W_MIN = EW'(-(longint'(1) <<< (WW - 1)));

  rfk_pkg::ctl_t          ctl_g_r;
  rfk_pkg::ctl_t          ctl_h_r;
  rfk_pkg::ctl_t          ctl_i_r;
  rfk_pkg::coef_t         cf_h;
  rfk_pkg::coef_t         cf_i;

  logic [NW-1:0]          mag_nxt;
  logic [NW-1:0]          mag_g_r;
  logic                   neg_g_r;
  logic                   neg_h_r;
  logic                   neg_i_r;
  logic [3:0]             odd_val;
  logic [NW:0]            rnd_sum;
  logic [QW-1:0]          quo_nxt;
  logic [QW-1:0]          quo_h_r;
  logic [S-1:0]           recip;
  logic [PW-1:0]          prod;
  logic [QB-1:0]          q_nxt;
  logic [QB-1:0]          q_i_r;
  logic signed [EW-1:0]   qs;
  logic signed [EW-1:0]   sw;
  logic signed [WW-1:0]   weight_nxt;
  logic signed [WW-1:0]   weight_r;
  logic                   valid_r;

  // Magnitude and sign of the exact numerator.
  assign mag_nxt = num_i[NW-1] ? -num_i : num_i;

  // Add half the denominator, then drop its power-of-two part.
  assign cf_h = rfk_pkg::piece_coef(ctl_g_r.piece);

  always_comb begin
    case (cf_h.odd)
      rfk_pkg::DIV_3: odd_val = 4'd3;
      rfk_pkg::DIV_9: odd_val = 4'd9;
      default:        odd_val = 4'd1;
    endcase
  end

  always_comb begin
    case (cf_h.pow2)
      2'd0: begin
        rnd_sum = (NW+1)'(mag_g_r) + ((NW+1)'(odd_val) << (K - 1));
        quo_nxt = QW'(rnd_sum >> K);
      end
      2'd1: begin
        rnd_sum = (NW+1)'(mag_g_r) + ((NW+1)'(odd_val) << K);
        quo_nxt = QW'(rnd_sum >> (K + 1));
      end
      2'd2: begin
        rnd_sum = (NW+1)'(mag_g_r) + ((NW+1)'(odd_val) << (K + 1));
        quo_nxt = QW'(rnd_sum >> (K + 2));
      end
      default: begin
        rnd_sum = (NW+1)'(mag_g_r) + ((NW+1)'(odd_val) << (K + 2));
        quo_nxt = QW'(rnd_sum >> (K + 3));
      end
    endcase
  end

  // Divide by the odd factor through a reciprocal multiply.
  assign cf_i  = rfk_pkg::piece_coef(ctl_h_r.piece);
  assign recip = (cf_i.odd == rfk_pkg::DIV_3) ? RECIP3 : RECIP9;
  assign prod  = PW'(quo_h_r) * PW'(recip);
  assign q_nxt = (cf_i.odd == rfk_pkg::DIV_1) ? QB'(quo_h_r) : QB'(prod >> S);

  // Restore the sign and clamp to the weight word.
  assign qs = signed'(EW'(q_i_r));
  assign sw = neg_i_r ? -qs : qs;

  always_comb begin
    if (sw > W_MAX) begin
      weight_nxt = W_MAX[WW-1:0];
    end else if (sw < W_MIN) begin
      weight_nxt = W_MIN[WW-1:0];
    end else begin
      weight_nxt = sw[WW-1:0];
    end
  end

  // Valid bits and piece codes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_g_r <= '0;
      ctl_h_r <= '0;
      ctl_i_r <= '0;
      valid_r <= 1'b0;
    end else if (adv) begin
      ctl_g_r <= ctl_i;
      ctl_h_r <= ctl_g_r;
      ctl_i_r <= ctl_h_r;
      valid_r <= ctl_i_r.valid;
    end
  end

  // Data stages, ending in the output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_g_r  <= mag_nxt;
      neg_g_r  <= num_i[NW-1];
      quo_h_r  <= quo_nxt;
      neg_h_r  <= neg_g_r;
      q_i_r    <= q_nxt;
      neg_i_r  <= neg_h_r;
      weight_r <= weight_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_weight = weight_r;

endmodule

>>> tb/resampling_filter_kernel_eval_top_tb.sv
`timescale 1ns / 1ps

module resampling_filter_kernel_eval_top_tb;

  localparam int IN_FRAC    = rfk_pkg::IN_FRAC_DEF;
  localparam int OUT_FRAC   = rfk_pkg::OUT_FRAC_DEF;
  localparam int PIPE_DEPTH = 10;
  localparam int MAX_CYCLES = 200000;
  localparam int RAND_WORDS = 52;

  // Codes 6 and 7 select no filter and must give zero weight.
  localparam logic [rfk_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [rfk_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

  typedef enum int {
    CHK_OK,
    CHK_BAD,
    CHK_ORPHAN
  } chk_t;

  // Holds the filter mode and the weights still due from the pipeline.
  class weight_scoreboard;
    logic [rfk_pkg::MODE_W-1:0]          mode;
    logic signed [rfk_pkg::WEIGHT_W-1:0] weight_q[$];

    function new();
      mode = rfk_pkg::MODE_BOX;
    endfunction

    // Exact rational weight of the selected filter, rounded once to Q1.14.
    function logic signed [rfk_pkg::WEIGHT_W-1:0] filter_weight(
        logic signed [rfk_pkg::OFFSET_W-1:0] off);
      longint s;
      longint t;
      longint a;
      longint a2;
      longint a3;
      longint num;
      longint den;
      longint u;
      longint d;
      longint mag;
      longint q;
      s   = longint'(1) << IN_FRAC;
      t   = off;
      a   = (t < 0) ? -t : t;
      a2  = a * a;
      a3  = a2 * a;
      num = 0;
      den = 1;
      case (mode)
        rfk_pkg::MODE_BOX: begin
          if (2 * t > -s && 2 * t <= s) num = s * s * s;
        end
        rfk_pkg::MODE_TRIANGLE: begin
          if (a < s) num = (s - a) * s * s;
        end
        rfk_pkg::MODE_HERMITE: begin
          if (a < s) num = 2 * a3 - 3 * a2 * s + s * s * s;
        end
        rfk_pkg::MODE_BELL: begin
          if (2 * a < s) begin
            num = 3 * s * s * s - 4 * a2 * s;
            den = 4;
          end else if (2 * a < 3 * s) begin
            u   = 2 * a - 3 * s;
            num = u * u * s;
            den = 8;
          end
        end
        rfk_pkg::MODE_BSPLINE: begin
          if (a < s) begin
            num = 3 * a3 - 6 * a2 * s + 4 * s * s * s;
            den = 6;
          end else if (a < 2 * s) begin
            u   = 2 * s - a;
            num = u * u * u;
            den = 6;
          end
        end
        rfk_pkg::MODE_MITCHELL: begin
          if (a < s) begin
            num = 21 * a3 - 36 * a2 * s + 16 * s * s * s;
            den = 18;
          end else if (a < 2 * s) begin
            num = -7 * a3 + 36 * a2 * s - 60 * a * s * s + 32 * s * s * s;
            den = 18;
          end
        end
        default: begin
          num = 0;
        end
      endcase
      // Round half away from zero, then saturate to the output field.
      d   = den << (3 * IN_FRAC - OUT_FRAC);
      mag = (num < 0) ? -num : num;
      q   = (mag + d / 2) / d;
      if (num < 0) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[rfk_pkg::WEIGHT_W-1:0];
    endfunction

    function void note_offset(logic signed [rfk_pkg::OFFSET_W-1:0] off);
      weight_q.push_back(filter_weight(off));
    endfunction

    function chk_t check_weight(logic signed [rfk_pkg::WEIGHT_W-1:0] got,
                                output logic signed [rfk_pkg::WEIGHT_W-1:0] want);
      want = '0;
      if (weight_q.size() == 0) return CHK_ORPHAN;
      want = weight_q.pop_front();
      if (got === want) return CHK_OK;
      return CHK_BAD;
    endfunction

    function int pending();
      return weight_q.size();
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst_n;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [rfk_pkg::MODE_W-1:0]           cfg_data;
  logic                                 in_valid;
  logic                                 in_ready;
  logic signed [rfk_pkg::OFFSET_W-1:0]  in_offset;
  logic                                 out_valid;
  logic                                 out_ready;
  logic signed [rfk_pkg::WEIGHT_W-1:0]  out_weight;

  weight_scoreboard sb;
  int               mismatches;
  int               cycles;
  bit               in_idle_on;
  bit               out_idle_on;

  resampling_filter_kernel_eval_top #(
    .IN_FRAC_BITS (IN_FRAC),
    .OUT_FRAC_BITS(OUT_FRAC)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_offset (in_offset),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_weight(out_weight)
  );

  // Free-running clock, 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offsets weighted toward the filter supports and their edges.
  function automatic logic signed [rfk_pkg::OFFSET_W-1:0] pick_offset();
    int unsigned raw;
    int          k;
    raw = $urandom();
    case ($urandom_range(0, 3))
      0: begin
        k = int'($urandom_range(0, 10)) - 5;
        k = k * 2048 + int'($urandom_range(0, 2)) - 1;
      end
      1: k = int'($urandom_range(0, 18000)) - 9000;
      2: k = int'($urandom_range(0, 2400)) - 1200;
      default: k = int'(raw[rfk_pkg::OFFSET_W-1:0]);
    endcase
    return k[rfk_pkg::OFFSET_W-1:0];
  endfunction

  // Sends one offset word; called and returns at a falling edge.
  task automatic send_offset(input logic signed [rfk_pkg::OFFSET_W-1:0] off);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_offset = off;
    do @(posedge clk); while (!in_ready);
    sb.note_offset(off);
    @(negedge clk);
  endtask

  // Waits until the pipeline is empty, then loads a new filter mode.
  task automatic write_mode(input logic [rfk_pkg::MODE_W-1:0] m);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = m;
    do @(posedge clk); while (!cfg_ready);
    sb.mode = m;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result side: random stalls, each accepted word checked in order.
  initial begin
    logic signed [rfk_pkg::WEIGHT_W-1:0] want;
    chk_t                                status;
    int                                  gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = out_idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      status = sb.check_weight(out_weight, want);
      if (status == CHK_ORPHAN) begin
        report_mismatch($sformatf("unexpected weight %0d", out_weight));
      end else if (status == CHK_BAD) begin
        report_mismatch($sformatf("weight %0d, expected %0d (mode %0d)",
                                  out_weight, want, sb.mode));
      end
      @(negedge clk);
    end
  end

  // Stimulus: reset, directed edges in box mode, then one phase per mode setting.
  initial begin
    logic signed [rfk_pkg::OFFSET_W-1:0] edge_offsets[$];
    logic [rfk_pkg::MODE_W-1:0]          mode_plan[$];
    sb          = new();
    mismatches  = 0;
    cycles      = 0;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = rfk_pkg::MODE_BOX;
    in_valid    = 1'b0;
    in_offset   = '0;

    edge_offsets = '{16'sh8000, 16'sd32767, 16'sd0, 16'sd1, -16'sd1,
                     16'sd2048, -16'sd2048, 16'sd2047, -16'sd2047, 16'sd2049,
                     16'sd4096, -16'sd4096, 16'sd4095, -16'sd4095, 16'sd6144,
                     -16'sd6144, 16'sd6143, 16'sd8192, -16'sd8192, 16'sd8191,
                     -16'sd8191, 16'sd12288};
    mode_plan = '{rfk_pkg::MODE_BOX, rfk_pkg::MODE_TRIANGLE, rfk_pkg::MODE_HERMITE,
                  rfk_pkg::MODE_BELL, rfk_pkg::MODE_BSPLINE, rfk_pkg::MODE_MITCHELL,
                  MODE_SPARE_A, MODE_SPARE_B, rfk_pkg::MODE_BOX, rfk_pkg::MODE_MITCHELL,
                  rfk_pkg::MODE_BELL, MODE_SPARE_B, rfk_pkg::MODE_BSPLINE,
                  rfk_pkg::MODE_BOX, rfk_pkg::MODE_TRIANGLE, rfk_pkg::MODE_HERMITE};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // The first phase runs on the reset value of the mode register.
    foreach (mode_plan[p]) begin
      if (p != 0) write_mode(mode_plan[p]);
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      if (p == 0) begin
        foreach (edge_offsets[i]) send_offset(edge_offsets[i]);
      end
      repeat (RAND_WORDS) send_offset(pick_offset());
    end
    in_valid = 1'b0;

    // Drain the pipeline and allow for any stray words.
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
    if (mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rfk_pkg.sv
hdl/rfk_front.sv
hdl/rfk_poly.sv
hdl/rfk_round.sv
hdl/resampling_filter_kernel_eval_top.sv
tb/resampling_filter_kernel_eval_top_tb.sv
